// ----- hw/rtl/clint_pkg.sv -----
package clint_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  localparam logic [63:0] BASE_RESET     = 64'h0000_0000_0200_0000;
  localparam logic [15:0] SOFT_END       = 16'h4000;
  localparam logic [15:0] TIME_OFF       = 16'h7FF8;
  localparam int unsigned HART_COUNT_DEF = 4;
  localparam int unsigned PEND_W         = 4;
  localparam int unsigned DATA_W         = 64;

  // decoded access, window-relative
  typedef struct packed {
    cmd_e        cmd;
    logic        in_win;
    logic [15:0] off;
  } clint_req_t;

endpackage

// ----- hw/rtl/core_local_interruptor.sv -----
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// config   | cfg_we_i               | cfg_wdata_i (base_address)
// input    | in_valid_i / in_ready_o| command_i, address_i, write_data_i
// output   | out_valid_o/out_ready_i| read_data_o, time_now_o, soft_pending_o,
//          |                        | timer_pending_o
//
// one item per cycle sustained while the output is taken. The window offset
// subtract sits before the input register; decode, state update and the timer
// compares sit before the result register.
// reset: mtime 0, compares all ones, msip clear, base 0x0200_0000.
// a stalled output holds its result; the input register keeps taking items
// until both stages are full.
module core_local_interruptor #(
  parameter int unsigned HART_COUNT = clint_pkg::HART_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [clint_pkg::DATA_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    command_i,
  input  logic [clint_pkg::DATA_W-1:0]  address_i,
  input  logic [clint_pkg::DATA_W-1:0]  write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [clint_pkg::DATA_W-1:0]  read_data_o,
  output logic [clint_pkg::DATA_W-1:0]  time_now_o,
  output logic [clint_pkg::PEND_W-1:0]  soft_pending_o,
  output logic [clint_pkg::PEND_W-1:0]  timer_pending_o
);
  import clint_pkg::*;

  logic [DATA_W-1:0] base_q;
  logic [DATA_W-1:0] off_full;
  logic              accept, advance, fire;

  logic              s1_valid_q, s1_valid_d;
  clint_req_t        s1_req_q, s1_req_d;
  logic [DATA_W-1:0] s1_wdata_q;

  logic [DATA_W-1:0] rd_c, time_c, time_cur;
  logic [PEND_W-1:0] sp_c, tp_c;

  logic              out_valid_q;
  logic [DATA_W-1:0] rd_q, time_q;
  logic [PEND_W-1:0] sp_q, tp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  assign off_full        = address_i - base_q;
  assign s1_req_d.cmd    = cmd_e'(command_i);
  assign s1_req_d.in_win = (off_full[DATA_W-1:16] == '0);
  assign s1_req_d.off    = off_full[15:0];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q   <= s1_req_d;
      s1_wdata_q <= write_data_i;
    end
  end

  clint_regs #(
    .HART_COUNT (HART_COUNT)
  ) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .req_i           (s1_req_q),
    .wdata_i         (s1_wdata_q),
    .read_data_o     (rd_c),
    .time_next_o     (time_c),
    .time_cur_o      (time_cur),
    .soft_pending_o  (sp_c),
    .timer_pending_o (tp_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_q   <= rd_c;
      time_q <= time_c;
      sp_q   <= sp_c;
      tp_q   <= tp_c;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rd_q;
  assign time_now_o      = time_q;
  assign soft_pending_o  = sp_q;
  assign timer_pending_o = tp_q;

`ifndef NO_ASSERTIONS
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while both stages are full");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_valid_o && time_now_o == time_cur))
    else $error("result missing or time mismatch after item");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_req_q.cmd == CMD_TICK) |=> (time_now_o == $past(time_cur) + 64'd1))
    else $error("tick did not advance time by one");
`endif

endmodule

// ----- hw/rtl/clint_regs.sv -----
module clint_regs #(
  parameter int unsigned HART_COUNT = clint_pkg::HART_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  clint_pkg::clint_req_t           req_i,
  input  logic [clint_pkg::DATA_W-1:0]    wdata_i,
  output logic [clint_pkg::DATA_W-1:0]    read_data_o,
  output logic [clint_pkg::DATA_W-1:0]    time_next_o,
  output logic [clint_pkg::DATA_W-1:0]    time_cur_o,
  output logic [clint_pkg::PEND_W-1:0]    soft_pending_o,
  output logic [clint_pkg::PEND_W-1:0]    timer_pending_o
);
  import clint_pkg::*;

  localparam int unsigned HW = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;
  localparam logic [12:0] HC = 13'(HART_COUNT);

  logic [DATA_W-1:0] time_q, time_d;
  logic [DATA_W-1:0] cmp_q [HART_COUNT];
  logic [DATA_W-1:0] cmp_d [HART_COUNT];
  logic [HART_COUNT-1:0] soft_q, soft_d;

  logic [15:0] t_off;
  logic [11:0] soft_h;
  logic [12:0] tc_h;
  logic        soft_sel, soft_ok, time_sel, tc_ok;
  logic [HW-1:0] soft_idx, tc_idx;

  // address decode
  assign t_off    = req_i.off - SOFT_END;
  assign soft_h   = req_i.off[13:2];
  assign tc_h     = t_off[15:3];
  assign soft_sel = req_i.in_win && (req_i.off[15:14] == 2'b00);
  assign soft_ok  = soft_sel && ({1'b0, soft_h} < HC);
  assign time_sel = req_i.in_win && !soft_sel && (tc_h == TIME_OFF[15:3]);
  assign tc_ok    = req_i.in_win && !soft_sel && !time_sel && (tc_h < HC);
  assign soft_idx = soft_h[HW-1:0];
  assign tc_idx   = tc_h[HW-1:0];

  always_comb begin
    read_data_o = '0;
    time_d      = time_q;
    soft_d      = soft_q;
    for (int h = 0; h < int'(HART_COUNT); h++) begin
      cmp_d[h] = cmp_q[h];
    end
    case (req_i.cmd)
      CMD_READ: begin
        if (soft_ok) begin
          read_data_o = {{(DATA_W-1){1'b0}}, soft_q[soft_idx]};
        end else if (time_sel) begin
          read_data_o = time_q;
        end else if (tc_ok) begin
          read_data_o = cmp_q[tc_idx];
        end
      end
      CMD_WRITE: begin
        if (soft_ok) begin
          soft_d[soft_idx] = wdata_i[0];
        end else if (time_sel) begin
          time_d = wdata_i;
        end else if (tc_ok) begin
          cmp_d[tc_idx] = wdata_i;
        end
      end
      CMD_TICK: begin
        time_d = time_q + 64'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
      soft_q <= '0;
      for (int h = 0; h < int'(HART_COUNT); h++) begin
        cmp_q[h] <= '1;
      end
    end else if (fire_i) begin
      time_q <= time_d;
      soft_q <= soft_d;
      for (int h = 0; h < int'(HART_COUNT); h++) begin
        cmp_q[h] <= cmp_d[h];
      end
    end
  end

  // pending bits reflect the state after this item
  for (genvar g = 0; g < int'(PEND_W); g++) begin : g_pend
    if (g < int'(HART_COUNT)) begin : g_hart
      assign soft_pending_o[g]  = soft_d[g];
      assign timer_pending_o[g] = (time_d >= cmp_d[g]);
    end else begin : g_none
      assign soft_pending_o[g]  = 1'b0;
      assign timer_pending_o[g] = 1'b0;
    end
  end

  assign time_next_o = time_d;
  assign time_cur_o  = time_q;

endmodule
